[design/disk_request_elevator_scheduler_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the disk request scheduler
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DISK_REQUEST_ELEVATOR_SCHEDULER_TOP_MACROS_SVH
`define DISK_REQUEST_ELEVATOR_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication.
`define DRS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/drs_pkg.sv]
// ----------------------------------------------------------------------------
// Disk request scheduler package
// Field widths, codes, defaults and the structs shared by the scheduler files.
// ----------------------------------------------------------------------------
package drs_pkg;

  localparam int BLOCK_W = 12;
  localparam int TAG_W   = 4;
  localparam int OCC_W   = 5;
  localparam int KEY_W   = BLOCK_W + 1;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int NUM_BLOCKS_DEF  = 4096;
  localparam int DATA_START_DEF  = 64;

  localparam logic OP_ENQUEUE  = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic               wr;
    logic [BLOCK_W-1:0] blk;
  } entry_t;

  // Running best of a dispatch scan as it walks down the row of cells.
  typedef struct packed {
    logic             tok;
    logic             found;
    logic [KEY_W-1:0] key;
    entry_t           entry;
  } scan_t;

  // Broadcast controls from the sequencer to every cell.
  typedef struct packed {
    logic               push;
    logic               pop;
    logic [BLOCK_W-1:0] head;
    entry_t             entry;
  } ctrl_t;

  typedef struct packed {
    logic               granted;
    logic [BLOCK_W-1:0] grant_block;
    logic               grant_write;
    logic [TAG_W-1:0]   grant_tag;
    status_t            status;
    logic [OCC_W-1:0]   occupancy;
  } res_t;

endpackage

[design/drs_ifaces.sv]
// ----------------------------------------------------------------------------
// Disk request scheduler channel interfaces
// Valid/ready channels for requests, results and the enable register write.
// ----------------------------------------------------------------------------
interface drs_req_if import drs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               operation;
  logic [BLOCK_W-1:0] blk_num;
  logic               wr_flag;
  logic [TAG_W-1:0]   tag;

  modport source (output valid, operation, blk_num, wr_flag, tag, input ready);
  modport sink   (input valid, operation, blk_num, wr_flag, tag, output ready);
endinterface

interface drs_res_if import drs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               granted;
  logic [BLOCK_W-1:0] grant_block;
  logic               grant_write;
  logic [TAG_W-1:0]   grant_tag;
  logic [1:0]         status;
  logic [OCC_W-1:0]   occupancy;

  modport source (output valid, granted, grant_block, grant_write, grant_tag, status,
                  occupancy, input ready);
  modport sink   (input valid, granted, grant_block, grant_write, grant_tag, status,
                  occupancy, output ready);
endinterface

interface drs_cfg_if ();
  logic valid;
  logic ready;
  logic scheduler_enable;

  modport source (output valid, scheduler_enable, input ready);
  modport sink   (input valid, scheduler_enable, output ready);
endinterface

[design/disk_request_elevator_scheduler_top.sv]
// ----------------------------------------------------------------------------
// Disk request elevator scheduler
// C-LOOK ordering of queued disk requests over a row of queue cells.
// ----------------------------------------------------------------------------
// An enqueue, or a dispatch on an empty queue, has its result registered and
// passed to the output register before the next request is accepted. A
// dispatch that finds requests starts a scan: the running best walks down the
// row of queue cells one cell per clock, then the winner is removed, the rest
// shift up by one together and the result is loaded into the output register.
// A result that waits in the output register does not stop the next request
// from being accepted. Valid bits are cleared by reset, so no clearing pass is
// needed.
`include "disk_request_elevator_scheduler_top_macros.svh"

module disk_request_elevator_scheduler_top import drs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
  parameter int DATA_START  = DATA_START_DEF
) (
  input logic      clk,
  input logic      rst_n,
  drs_req_if.sink  in_req,
  drs_res_if.source out_res,
  drs_cfg_if.sink  cfg_wr
);

  localparam int IW      = $clog2(QUEUE_DEPTH);
  localparam int CW      = $clog2(QUEUE_DEPTH + 1);
  localparam int RANGE_W = 17;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } state_t;

  state_t           state_r;
  logic [CW-1:0]    count_r;
  logic [BLOCK_W-1:0] head_r;
  logic             enable_r;
  logic             scan_start_r;
  logic             out_valid_r;
  res_t             out_r;
  res_t             res_r;

  logic [QUEUE_DEPTH-1:0] cell_valid;
  entry_t           cell_entry [QUEUE_DEPTH];
  scan_t            scan_link  [QUEUE_DEPTH+1];
  logic [IW-1:0]    scan_idx   [QUEUE_DEPTH+1];

  ctrl_t            ctrl;
  logic             in_acc;
  logic             in_range;
  logic             full;
  logic             push;
  logic             scan_done;
  entry_t           req_entry;
  res_t             imm_res;
  res_t             pop_res;

  assign in_acc    = in_req.valid && in_req.ready;
  assign in_range  = (RANGE_W'(in_req.blk_num) >= RANGE_W'(DATA_START)) &&
                     (RANGE_W'(in_req.blk_num) <  RANGE_W'(NUM_BLOCKS));
  assign full      = (count_r == CW'(QUEUE_DEPTH));
  assign push      = in_acc && (in_req.operation == OP_ENQUEUE) && in_range &&
                     enable_r && !full;
  assign scan_done = (state_r == ST_SCAN) && scan_link[QUEUE_DEPTH].tok;

  assign req_entry.blk = in_req.blk_num;
  assign req_entry.wr  = in_req.wr_flag;
  assign req_entry.tag = in_req.tag;

  assign ctrl.push  = push;
  assign ctrl.pop   = scan_done;
  assign ctrl.head  = head_r;
  assign ctrl.entry = req_entry;

  assign scan_link[0].tok   = scan_start_r;
  assign scan_link[0].found = 1'b0;
  assign scan_link[0].key   = '0;
  assign scan_link[0].entry = '0;
  assign scan_idx[0]        = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   prev_valid;
    logic   next_valid;
    entry_t next_entry;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_valid = cell_valid[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_entry = '0;
    end else begin : g_inner
      assign next_valid = cell_valid[i+1];
      assign next_entry = cell_entry[i+1];
    end

    drs_cell #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .IDX         (i)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .pop_idx      (scan_idx[QUEUE_DEPTH]),
      .prev_valid   (prev_valid),
      .next_valid   (next_valid),
      .next_entry   (next_entry),
      .scan_in      (scan_link[i]),
      .scan_idx_in  (scan_idx[i]),
      .scan_out     (scan_link[i+1]),
      .scan_idx_out (scan_idx[i+1]),
      .cell_valid   (cell_valid[i]),
      .cell_entry   (cell_entry[i])
    );
  end

  // Result of a request that finishes in the cycle it is accepted.
  always_comb begin
    imm_res           = '0;
    imm_res.status    = STAT_OK;
    imm_res.occupancy = OCC_W'(count_r + CW'(push));
    if (in_req.operation == OP_ENQUEUE) begin
      if (!in_range) begin
        imm_res.status = STAT_RANGE;
      end else if (!enable_r) begin
        imm_res.granted     = 1'b1;
        imm_res.grant_block = in_req.blk_num;
        imm_res.grant_write = in_req.wr_flag;
        imm_res.grant_tag   = in_req.tag;
      end else if (full) begin
        imm_res.status = STAT_FULL;
      end
    end else begin
      imm_res.status = STAT_EMPTY;
    end
  end

  always_comb begin
    pop_res             = '0;
    pop_res.granted     = 1'b1;
    pop_res.grant_block = scan_link[QUEUE_DEPTH].entry.blk;
    pop_res.grant_write = scan_link[QUEUE_DEPTH].entry.wr;
    pop_res.grant_tag   = scan_link[QUEUE_DEPTH].entry.tag;
    pop_res.status      = STAT_OK;
    pop_res.occupancy   = OCC_W'(count_r - CW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      head_r       <= BLOCK_W'(DATA_START);
      enable_r     <= 1'b1;
      scan_start_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      scan_start_r <= in_acc && (in_req.operation == OP_DISPATCH) && (count_r != '0);
      if (cfg_wr.valid && cfg_wr.ready) begin
        enable_r <= cfg_wr.scheduler_enable;
      end
      // In ST_WAIT the output register is reloaded below instead.
      if (out_valid_r && out_res.ready && (state_r != ST_WAIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if ((in_req.operation == OP_DISPATCH) && (count_r != '0)) begin
              state_r <= ST_SCAN;
            end else begin
              res_r   <= imm_res;
              count_r <= count_r + CW'(push);
              state_r <= ST_WAIT;
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            res_r   <= pop_res;
            head_r  <= scan_link[QUEUE_DEPTH].entry.blk;
            count_r <= count_r - CW'(1);
            state_r <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (!out_valid_r || out_res.ready) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_req.ready = (state_r == ST_IDLE);
  assign cfg_wr.ready = 1'b1;

  assign out_res.valid       = out_valid_r;
  assign out_res.granted     = out_r.granted;
  assign out_res.grant_block = out_r.grant_block;
  assign out_res.grant_write = out_r.grant_write;
  assign out_res.grant_tag   = out_r.grant_tag;
  assign out_res.status      = out_r.status;
  assign out_res.occupancy   = out_r.occupancy;

  // The fill count must always match the cells that hold a request.
  `DRS_ASSERT(a_count_matches, 1'b1, $countones(cell_valid) == count_r, "count mismatch")
  // Occupied cells stay packed toward the oldest end of the row.
  `DRS_ASSERT(a_compacted, 1'b1, ((cell_valid + 1'b1) & cell_valid) == '0, "queue has a gap")
  // A scan over a nonempty queue always ends with a winner.
  `DRS_ASSERT(a_scan_found, scan_done, scan_link[QUEUE_DEPTH].found, "scan found nothing")
  // A dispatch on an empty queue reports empty without starting a scan.
  `DRS_ASSERT_NEXT(a_empty_dispatch,
    in_acc && (in_req.operation == OP_DISPATCH) && (count_r == '0),
    (state_r == ST_WAIT) && (res_r.status == STAT_EMPTY) && !scan_start_r,
    "empty dispatch mishandled")

endmodule

[design/drs_cell.sv]
// ----------------------------------------------------------------------------
// Disk request scheduler queue cell
// Holds one queued request, takes part in the dispatch scan and compaction.
// ----------------------------------------------------------------------------
module drs_cell import drs_pkg::*; #(
  parameter int  QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int  IDX         = 0,
  localparam int IW          = $clog2(QUEUE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ctrl_t         ctrl,
  input  logic [IW-1:0] pop_idx,
  input  logic          prev_valid,
  input  logic          next_valid,
  input  entry_t        next_entry,
  input  scan_t         scan_in,
  input  logic [IW-1:0] scan_idx_in,
  output scan_t         scan_out,
  output logic [IW-1:0] scan_idx_out,
  output logic          cell_valid,
  output entry_t        cell_entry
);

  logic          valid_r;
  entry_t        entry_r;
  scan_t         scan_r;
  scan_t         scan_nxt;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] idx_nxt;
  logic [KEY_W-1:0] key;
  logic          take;

  // Blocks below the head rank after every block at or above it.
  assign key  = {entry_r.blk < ctrl.head, entry_r.blk};
  assign take = scan_in.tok && valid_r && (!scan_in.found || key < scan_in.key);

  always_comb begin
    scan_nxt = scan_in;
    idx_nxt  = scan_idx_in;
    if (take) begin
      scan_nxt.found = 1'b1;
      scan_nxt.key   = key;
      scan_nxt.entry = entry_r;
      idx_nxt        = IW'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      scan_r.tok <= 1'b0;
    end else begin
      scan_r <= scan_nxt;
      idx_r  <= idx_nxt;
      if (ctrl.pop && (IW'(IDX) >= pop_idx)) begin
        valid_r <= next_valid;
        entry_r <= next_entry;
      end else if (ctrl.push && !valid_r && prev_valid) begin
        valid_r <= 1'b1;
        entry_r <= ctrl.entry;
      end
    end
  end

  assign scan_out     = scan_r;
  assign scan_idx_out = idx_r;
  assign cell_valid   = valid_r;
  assign cell_entry   = entry_r;

endmodule
